// ----- src/assert_macros.svh -----
// Assertion helper macros shared by the checker files.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while rst is high.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("port check failed");

// Next-cycle implication, off while rst is high.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("port check failed");

// Next-cycle implication that also runs through reset.
`define ASSERT_NEXT_NR(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

// ----- src/mfhs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, header codes and lookup tables for the MP3 header scanner.
// No dependencies.
package mfhs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] hdr_offset;
    logic [10:0] frame_length;
    logic [15:0] sample_rate_hz;
    logic [10:0] frame_samples;
  } out_t;

  // Header bits: version(2), bitrate index(4), rate index(2), padding(1).
  typedef struct packed {
    logic        found;
    logic [31:0] offset;
    logic [8:0]  bits;
  } job_t;

  localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;
  localparam logic [7:0]  SYNC_BYTE   = 8'hFF;
  localparam logic [7:0]  SYNC_MASK   = 8'hE0;
  localparam logic [7:0]  ID3_I       = 8'h49;
  localparam logic [7:0]  ID3_D       = 8'h44;
  localparam logic [7:0]  ID3_3       = 8'h33;
  localparam logic [31:0] TAG_HDR_LEN = 32'd10;

  localparam logic [1:0] VER_25    = 2'd0;
  localparam logic [1:0] VER_RES   = 2'd1;
  localparam logic [1:0] VER_2     = 2'd2;
  localparam logic [1:0] VER_1     = 2'd3;
  localparam logic [1:0] LAYER_III = 2'd1;
  localparam logic [1:0] SRI_RES   = 2'd3;
  localparam logic [3:0] BRI_FREE  = 4'd0;
  localparam logic [3:0] BRI_BAD   = 4'd15;

  localparam logic [17:0] COEF_V1 = 18'd144000;
  localparam logic [17:0] COEF_V2 = 18'd72000;
  localparam logic [10:0] SPF_V1  = 11'd1152;
  localparam logic [10:0] SPF_V2  = 11'd576;

  // Divider geometry: quotient never exceeds 1440, so 11 steps suffice.
  localparam int DIV_STEPS = 11;
  localparam int PROD_W    = 26;
  localparam int CNT_W     = 4;

  // Job queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic [8:0] KBPS_V1 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
  };
  localparam logic [8:0] KBPS_V2 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
  };

  function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
    logic [15:0] r;
    case (ver)
      VER_1: begin
        case (sri)
          2'd1:    r = 16'd48000;
          2'd2:    r = 16'd32000;
          default: r = 16'd44100;
        endcase
      end
      VER_2: begin
        case (sri)
          2'd1:    r = 16'd24000;
          2'd2:    r = 16'd16000;
          default: r = 16'd22050;
        endcase
      end
      default: begin
        case (sri)
          2'd1:    r = 16'd12000;
          2'd2:    r = 16'd8000;
          default: r = 16'd11025;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

// ----- src/mfhs_queue.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between the byte front end and the result back end.
// Depends on mfhs_pkg.
module mfhs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mfhs_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output mfhs_pkg::job_t rdata,
  output logic          empty
);
  import mfhs_pkg::*;

  job_t              slot [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = slot[rptr];
  assign do_wr = push && !full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        slot[wptr] <= wdata;
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/mfhs_front.sv -----
`timescale 1ns / 1ps
// Byte front end: ID3 skip, sync search and result scheduling per file.
// Depends on mfhs_pkg.
module mfhs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  mfhs_pkg::in_t  item,
  output logic           job_push,
  output mfhs_pkg::job_t job
);
  import mfhs_pkg::*;

  logic [31:0] pos;
  logic [23:0] recent;
  logic        tag;
  logic [31:0] scan_start;
  logic        held_valid;
  logic [31:0] held_offset;
  logic [8:0]  held_bits;
  logic        sent;

  logic        active;
  logic        tag_hit;
  logic        in_scan;
  logic [31:0] p;
  logic        hdr_ok;
  logic [8:0]  hdr_bits;
  logic        det;
  logic        hv;
  logic [31:0] ho;
  logic [8:0]  hb;
  logic        emit;
  logic        none;
  logic [31:0] tag_end;

  always_comb begin
    logic [7:0] b1;
    logic [7:0] b2;
    b1 = recent[15:8];
    b2 = recent[7:0];
    hdr_bits = {b1[4:3], b2[7:4], b2[3:2], b2[1]};
    hdr_ok = (recent[23:16] == SYNC_BYTE) && ((b1 & SYNC_MASK) == SYNC_MASK) &&
             (b1[2:1] == LAYER_III) && (b1[4:3] != VER_RES) &&
             (b2[3:2] != SRI_RES) && (b2[7:4] != BRI_FREE) && (b2[7:4] != BRI_BAD);
  end

  assign active  = !sent && (pos != POS_MAX);
  assign tag_hit = active && (pos == 32'd2) && (recent[15:8] == ID3_I) &&
                   (recent[7:0] == ID3_D) && (item.data_byte == ID3_3);
  assign p       = pos - 32'd3;
  // With a tag, the scan start is known from the tenth byte on and is at least 10.
  assign in_scan = !tag || ((pos >= TAG_HDR_LEN) && (p >= scan_start));
  assign det     = active && (pos >= 32'd3) && !held_valid && in_scan && hdr_ok;
  assign hv      = held_valid || det;
  assign ho      = det ? p : held_offset;
  assign hb      = det ? hdr_bits : held_bits;
  assign emit    = active && (pos >= 32'd9) && hv;
  assign none    = item.last_byte && !emit && !sent;
  assign tag_end = TAG_HDR_LEN + {4'd0, recent[22:16], recent[14:8], recent[6:0],
                                  item.data_byte[6:0]};

  assign job_push   = accept && (emit || none);
  assign job.found  = emit;
  assign job.offset = emit ? ho : '0;
  assign job.bits   = emit ? hb : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      recent     <= '0;
      tag        <= 1'b0;
      scan_start <= '0;
      held_valid <= 1'b0;
      held_offset <= '0;
      held_bits  <= '0;
      sent       <= 1'b0;
    end else if (accept) begin
      if (item.last_byte) begin
        pos        <= '0;
        recent     <= '0;
        tag        <= 1'b0;
        scan_start <= '0;
        held_valid <= 1'b0;
        held_offset <= '0;
        held_bits  <= '0;
        sent       <= 1'b0;
      end else begin
        recent <= {recent[15:0], item.data_byte};
        if (pos != POS_MAX) begin
          pos <= pos + 32'd1;
        end
        if (tag_hit) begin
          tag <= 1'b1;
        end
        if (active && tag && (pos == 32'd9)) begin
          scan_start <= tag_end;
        end
        if (det) begin
          held_valid  <= 1'b1;
          held_offset <= p;
          held_bits   <= hdr_bits;
        end
        if (emit) begin
          sent <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/mfhs_back.sv -----
`timescale 1ns / 1ps
// Result back end: table lookups, length multiply, 11-step divide, result register.
// Depends on mfhs_pkg.
module mfhs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  mfhs_pkg::job_t job,
  output logic           q_pop,
  output mfhs_pkg::out_t result,
  output logic           empty,
  input  logic           pop
);
  import mfhs_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_HOLD} bstate_t;

  bstate_t           state;
  logic              found_r;
  logic [31:0]       offset_r;
  logic              pad_r;
  logic              v1_r;
  logic [15:0]       rate_r;
  logic [8:0]        kbps_r;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsr;
  logic [10:0]       quo;
  logic [CNT_W-1:0]  cnt;
  logic              out_valid;
  out_t              out_r;

  logic [17:0]       coef;
  logic [26:0]       prod;
  logic              ge;

  assign q_pop  = (state == B_IDLE) && !q_empty;
  assign empty  = !out_valid;
  assign result = out_r;
  assign coef   = v1_r ? COEF_V1 : COEF_V2;
  assign prod   = coef * kbps_r;
  assign ge     = (rem >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            found_r  <= job.found;
            offset_r <= job.offset;
            pad_r    <= job.bits[0];
            v1_r     <= (job.bits[8:7] == VER_1);
            rate_r   <= rate_lookup(job.bits[8:7], job.bits[2:1]);
            kbps_r   <= (job.bits[8:7] == VER_1) ? KBPS_V1[job.bits[6:3]]
                                                 : KBPS_V2[job.bits[6:3]];
            quo      <= '0;
            state    <= job.found ? B_MUL : B_HOLD;
          end
        end
        B_MUL: begin
          rem   <= prod[PROD_W-1:0];
          dsr   <= PROD_W'({rate_r, {(DIV_STEPS - 1){1'b0}}});
          cnt   <= CNT_W'(DIV_STEPS - 1);
          state <= B_DIV;
        end
        B_DIV: begin
          if (ge) begin
            rem <= rem - dsr;
          end
          quo <= {quo[9:0], ge};
          dsr <= dsr >> 1;
          if (cnt == '0) begin
            state <= B_HOLD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        B_HOLD: begin
          if (!out_valid) begin
            out_valid            <= 1'b1;
            out_r.found          <= found_r;
            out_r.hdr_offset     <= found_r ? offset_r : '0;
            out_r.frame_length   <= found_r ? quo + {10'd0, pad_r} : '0;
            out_r.sample_rate_hz <= found_r ? rate_r : '0;
            out_r.frame_samples  <= found_r ? (v1_r ? SPF_V1 : SPF_V2) : '0;
            state                <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mp3_frame_header_scanner_core.sv -----
`timescale 1ns / 1ps
// Top level of the MP3 frame header scanner: front end, job queue, back end.
// Depends on mfhs_pkg, mfhs_front, mfhs_queue, mfhs_back.

// Bytes of one file go in one beat per clock, with last_byte on the final byte.
// The front end skips an ID3 tag by its syncsafe size, finds the first valid
// Layer III header and queues one job per file (found, or not found at the
// last byte). Input runs at one byte per cycle while the two-entry job queue
// has room; full rises only when two jobs are waiting. The back end takes
// one job at a time: table lookup, one 18x9 multiply, an 11-step restoring
// divide by the sample rate, result load; a not-found job skips multiply and
// divide. The divider sets how fast back-to-back short files can be taken.
// The result waits in a one-beat output register until popped; bytes after
// the reported header are absorbed until last_byte, which re-arms the block.
module mp3_frame_header_scanner_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  mfhs_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output mfhs_pkg::out_t result
);
  import mfhs_pkg::*;

  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic q_empty;
  logic q_pop;

  // A byte is taken only when the queue can hold any job it may produce.
  assign accept = push && !full;

  mfhs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  mfhs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (q_pop),
    .rdata (job_out),
    .empty (q_empty)
  );

  mfhs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .job     (job_out),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

// ----- src/mfhs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the scanner top, bound onto every instance.
// Depends on mfhs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mfhs_checker (
  input logic           clk,
  input logic           rst,
  input logic           full,
  input logic           empty,
  input logic           pop,
  input mfhs_pkg::out_t result
);
  import mfhs_pkg::*;

  logic fields_zero;
  logic found_shape;

  assign fields_zero = (result.hdr_offset == 32'd0) && (result.frame_length == 11'd0) &&
                       (result.sample_rate_hz == 16'd0) && (result.frame_samples == 11'd0);
  assign found_shape = ((result.frame_samples == SPF_V1) || (result.frame_samples == SPF_V2)) &&
                       (result.frame_length != 11'd0) && (result.sample_rate_hz != 16'd0);

  `ASSERT_NEXT_NR(a_rst_empty, rst, empty)
  `ASSERT_NEXT_NR(a_rst_not_full, rst, !full)
  `ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result))
  `ASSERT_IMP(a_none_zero, !empty && !result.found, fields_zero)
  `ASSERT_IMP(a_found_shape, !empty && result.found, found_shape)

endmodule

bind mp3_frame_header_scanner_core mfhs_checker u_chk (.*);
